>>> rtl/core/pida_pkg.sv
package pida_pkg;

  localparam int POS_W = 6;
  localparam int CNT_W = 7;
  localparam int OUT_W = 32;

  typedef enum logic [1:0] {
    ACT_SHOW   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_BAD_POS = 2'd1,
    STS_FULL    = 2'd2,
    STS_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SHOW
  } fsm_t;

  typedef struct packed {
    cell_op_t           op;
    logic [CNT_W-1:0]   pos;
    logic [CNT_W-1:0]   tail;
  } cell_ctrl_t;

endpackage

>>> rtl/core/pida_cell.sv
module pida_cell
  import pida_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [DATA_WIDTH-1:0] left,
  input  logic [DATA_WIDTH-1:0] right,
  input  logic [DATA_WIDTH-1:0] head,
  input  logic [DATA_WIDTH-1:0] value,
  output logic [DATA_WIDTH-1:0] q
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [DATA_WIDTH-1:0] q_next;

  always_comb begin
    q_next = q;
    unique case (ctrl.op)
      CELL_HOLD: q_next = q;
      CELL_INSERT: begin
        if (MY_IDX > ctrl.pos) begin
          q_next = left;
        end else if (MY_IDX == ctrl.pos) begin
          q_next = value;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= ctrl.pos) begin
          q_next = right;
        end
      end
      CELL_ROTATE: begin
        if (MY_IDX < ctrl.tail) begin
          q_next = right;
        end else if (MY_IDX == ctrl.tail) begin
          q_next = head;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> rtl/core/positional_insert_delete_array_top.sv
// Insert, delete, no-op and rejected requests and an empty display give one result in
// the cycle after the transfer, and a new item is taken every cycle while results are
// being taken. A display of N entries gives N results, one per cycle while results are
// being taken, as the cell chain rotates once through the list; the next item can be
// taken from the cycle after the last one is loaded. Synchronous reset empties the list
// and clears the output valid; entry contents stay undefined until written.
module positional_insert_delete_array_top
  import pida_pkg::*;
#(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              action,
  input  logic signed [OUT_W-1:0] value,
  input  logic [POS_W-1:0]        position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  output logic signed [OUT_W-1:0] element,
  output logic [POS_W-1:0]        element_index,
  output logic [CNT_W-1:0]        entry_count,
  output logic                    last
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  fsm_t             state;
  fsm_t             state_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;

  logic [DATA_WIDTH-1:0] cells [DEPTH];
  logic [DATA_WIDTH-1:0] store_value;
  cell_ctrl_t            ctrl;

  logic             accept;
  logic             out_free;
  logic             load;
  logic             show_done;
  logic [CNT_W-1:0] count_w;
  logic [CNT_W-1:0] pos_w;

  status_t                 status_next;
  logic signed [OUT_W-1:0] element_next;
  logic [POS_W-1:0]        element_index_next;
  logic [CNT_W-1:0]        entry_count_next;
  logic                    last_next;

  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = (state != FSM_IDLE) || !out_free;
  assign accept      = in_valid && !in_stall;
  assign count_w     = CNT_W'(count);
  assign pos_w       = CNT_W'(position);
  assign store_value = DATA_WIDTH'(value);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pida_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .IDX       (i)
    ) u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .left (cells[(i == 0) ? 0 : i - 1]),
      .right(cells[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
      .head (cells[0]),
      .value(store_value),
      .q    (cells[i])
    );
  end

  always_comb begin
    ctrl.op            = CELL_HOLD;
    ctrl.pos           = pos_w;
    ctrl.tail          = count_w - CNT_W'(1);
    load               = 1'b0;
    show_done          = 1'b0;
    count_next         = count;
    idx_next           = idx;
    status_next        = STS_OK;
    element_next       = '0;
    element_index_next = '0;
    entry_count_next   = count_w;
    last_next          = 1'b1;
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          idx_next = '0;
          load     = 1'b1;
          unique case (action_t'(action))
            ACT_SHOW: begin
              if (count == '0) begin
                status_next = STS_EMPTY;
              end else begin
                load = 1'b0;
              end
            end
            ACT_INSERT: begin
              if (count_w >= FULL_CNT) begin
                status_next = STS_FULL;
              end else if (pos_w > count_w) begin
                status_next = STS_BAD_POS;
              end else begin
                ctrl.op          = CELL_INSERT;
                count_next       = count + CW'(1);
                entry_count_next = count_w + CNT_W'(1);
              end
            end
            ACT_DELETE: begin
              if (pos_w >= count_w) begin
                status_next = STS_BAD_POS;
              end else begin
                ctrl.op          = CELL_DELETE;
                count_next       = count - CW'(1);
                entry_count_next = count_w - CNT_W'(1);
              end
            end
            default: status_next = STS_OK;
          endcase
        end
      end
      FSM_SHOW: begin
        if (out_free) begin
          load               = 1'b1;
          ctrl.op            = CELL_ROTATE;
          element_next       = OUT_W'($signed(cells[0]));
          element_index_next = POS_W'(idx);
          last_next          = (CNT_W'(idx) == ctrl.tail);
          show_done          = last_next;
          idx_next           = idx + IDX_W'(1);
        end
      end
      default: load = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (accept && action_t'(action) == ACT_SHOW && count != '0) begin
          state_next = FSM_SHOW;
        end
      end
      FSM_SHOW: begin
        if (show_done) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status        <= status_next;
      element       <= element_next;
      element_index <= element_index_next;
      entry_count   <= entry_count_next;
      last          <= last_next;
    end
  end

endmodule

>>> rtl/core/pida_checker.sv
module pida_checker
  import pida_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [1:0]              status,
  input logic signed [OUT_W-1:0] element,
  input logic [POS_W-1:0]        element_index,
  input logic [CNT_W-1:0]        entry_count,
  input logic                    last
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && out_stall) && !$past(rst) |-> out_valid && $stable(status)
      && $stable(element) && $stable(element_index) && $stable(last))
    else $error("stalled result changed");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input open while a result transfer was stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_reject_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STS_OK |-> last && element == '0 && element_index == '0)
    else $error("rejected request gave a non-final or nonzero result");

endmodule

bind positional_insert_delete_array_top pida_checker #(.DEPTH(DEPTH)) u_pida_checker (.*);
